[src/vle_pkg.sv]
// Package for the value list engine: payload structs, operation and status codes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package vle_pkg;
   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);

   localparam logic [2:0] OP_ADD_FRONT = 3'd0;
   localparam logic [2:0] OP_APPEND    = 3'd1;
   localparam logic [2:0] OP_DELETE    = 3'd2;
   localparam logic [2:0] OP_SORT      = 3'd3;
   localparam logic [2:0] OP_DUMP      = 3'd4;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_MISSING = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   typedef struct packed {
      logic [2:0]         operation;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] item_value;
      logic [1:0]         status;
      logic [4:0]         entry_count;
      logic               last;
   } rsp_type;
endpackage
`default_nettype wire

[src/vle_cmd_fifo.sv]
// Two-entry command queue between the front end and the list engine.
// Depends on vle_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vle_cmd_fifo (
   input  wire              clock,
   input  wire              reset,
   input  vle_pkg::req_type wr_data,
   input  wire              wr_en,
   output logic             full,
   output vle_pkg::req_type rd_data,
   output logic             empty,
   input  wire              rd_en
);
   import vle_pkg::*;
   req_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign rd_data = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_en && !full) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         if (wr_en && !full) wp_ff <= ~wp_ff;
         if (rd_en && !empty) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr_en && !full} - {1'b0, rd_en && !empty};
      end
   end
endmodule
`default_nettype wire

[src/vle_engine.sv]
// List engine: holds the entries and runs one command at a time, one step per cycle
// unless a result still waits in the output register. Depends on vle_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vle_engine (
   input  wire              clock,
   input  wire              reset,
   input  vle_pkg::req_type cmd,
   input  wire              cmd_valid,
   output logic             cmd_take,
   output vle_pkg::rsp_type rsp_data,
   output logic             rsp_valid,
   input  wire              rsp_ready
);
   import vle_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_FIND, S_SHIFT_DN, S_SHIFT_UP, S_SORT, S_DUMP, S_DONE
   } state_type;

   state_type                 state_ff;
   logic signed [31:0]        store_ff [CAPACITY];
   logic [CNT_W-1:0]          total_ff;
   logic [CNT_W-1:0]          i_ff, j_ff;
   logic signed [31:0]        key_ff;
   req_type                   cmd_ff;
   rsp_type                   rsp_ff;
   logic                      rv_ff;
   logic                      out_free;
   logic                      rv_set;

   assign out_free  = !rv_ff || rsp_ready;
   assign rv_set    = out_free && (state_ff == S_DONE || state_ff == S_DUMP);
   assign rsp_data  = rsp_ff;
   assign rsp_valid = rv_ff;
   // take a command only once the output register is free to be rewritten
   assign cmd_take  = (state_ff == S_IDLE) && cmd_valid && out_free;

   function automatic rsp_type mk(logic signed [31:0] v, logic [1:0] st,
                                  logic [CNT_W-1:0] n, logic l);
      rsp_type r;
      r.item_value  = v;
      r.status      = st;
      r.entry_count = 5'(n);
      r.last        = l;
      return r;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         total_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         if (rv_set) rv_ff <= 1'b1;
         else if (rsp_ready) rv_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid && out_free) begin
                  cmd_ff <= cmd;
                  unique case (cmd.operation)
                     OP_ADD_FRONT: begin
                        if (total_ff == CNT_W'(CAPACITY)) begin
                           rsp_ff <= mk('0, ST_FULL, total_ff, 1'b1); state_ff <= S_DONE;
                        end else begin
                           i_ff <= total_ff; state_ff <= S_SHIFT_UP;
                        end
                     end
                     OP_APPEND: begin
                        if (total_ff == CNT_W'(CAPACITY)) begin
                           rsp_ff <= mk('0, ST_FULL, total_ff, 1'b1);
                        end else begin
                           store_ff[total_ff[IDX_W-1:0]] <= cmd.value;
                           total_ff <= total_ff + 1'b1;
                           rsp_ff <= mk('0, ST_OK, total_ff + 1'b1, 1'b1);
                        end
                        state_ff <= S_DONE;
                     end
                     OP_DELETE: begin
                        if (total_ff == '0) begin
                           rsp_ff <= mk('0, ST_EMPTY, total_ff, 1'b1); state_ff <= S_DONE;
                        end else begin
                           i_ff <= '0; state_ff <= S_FIND;
                        end
                     end
                     OP_SORT: begin
                        i_ff <= CNT_W'(1); j_ff <= CNT_W'(1);
                        key_ff <= store_ff[1];
                        state_ff <= S_SORT;
                     end
                     OP_DUMP: begin
                        if (total_ff == '0) begin
                           rsp_ff <= mk('0, ST_EMPTY, total_ff, 1'b1); state_ff <= S_DONE;
                        end else begin
                           i_ff <= '0; state_ff <= S_DUMP;
                        end
                     end
                     default: begin
                        rsp_ff <= mk('0, ST_OK, total_ff, 1'b1); state_ff <= S_DONE;
                     end
                  endcase
               end
            end
            S_SHIFT_UP: begin
               // move entries up one place, then drop the new value at the head
               if (i_ff == '0) begin
                  store_ff[0] <= cmd_ff.value;
                  total_ff <= total_ff + 1'b1;
                  rsp_ff <= mk('0, ST_OK, total_ff + 1'b1, 1'b1);
                  state_ff <= S_DONE;
               end else begin
                  store_ff[i_ff[IDX_W-1:0]] <= store_ff[IDX_W'(i_ff - 1'b1)];
                  i_ff <= i_ff - 1'b1;
               end
            end
            S_FIND: begin
               if (i_ff == total_ff) begin
                  rsp_ff <= mk('0, ST_MISSING, total_ff, 1'b1); state_ff <= S_DONE;
               end else if (store_ff[i_ff[IDX_W-1:0]] == cmd_ff.value) begin
                  state_ff <= S_SHIFT_DN;
               end else i_ff <= i_ff + 1'b1;
            end
            S_SHIFT_DN: begin
               if (i_ff + 1'b1 >= total_ff) begin
                  total_ff <= total_ff - 1'b1;
                  rsp_ff <= mk('0, ST_OK, total_ff - 1'b1, 1'b1);
                  state_ff <= S_DONE;
               end else begin
                  store_ff[i_ff[IDX_W-1:0]] <= store_ff[IDX_W'(i_ff + 1'b1)];
                  i_ff <= i_ff + 1'b1;
               end
            end
            S_SORT: begin
               // insertion sort: one compare and move per cycle
               if (i_ff >= total_ff) begin
                  rsp_ff <= mk('0, ST_OK, total_ff, 1'b1); state_ff <= S_DONE;
               end else if (j_ff != '0 && key_ff < store_ff[IDX_W'(j_ff - 1'b1)]) begin
                  store_ff[j_ff[IDX_W-1:0]] <= store_ff[IDX_W'(j_ff - 1'b1)];
                  j_ff <= j_ff - 1'b1;
               end else begin
                  store_ff[j_ff[IDX_W-1:0]] <= key_ff;
                  i_ff <= i_ff + 1'b1;
                  j_ff <= i_ff + 1'b1;
                  key_ff <= store_ff[IDX_W'(i_ff + 1'b1)];
               end
            end
            S_DUMP: begin
               if (out_free) begin
                  rsp_ff <= mk(store_ff[i_ff[IDX_W-1:0]], ST_OK, total_ff,
                               i_ff + 1'b1 == total_ff);
                  i_ff <= i_ff + 1'b1;
                  if (i_ff + 1'b1 == total_ff) state_ff <= S_IDLE;
               end
            end
            S_DONE: begin
               if (out_free) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= CNT_W'(CAPACITY)) else $error("entry count over capacity");
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> state_ff != S_IDLE) else $error("command taken without work");
   a_total_step: assert property (@(posedge clock) disable iff (reset)
      total_ff != $past(total_ff) |-> $past(state_ff) != S_DUMP && $past(state_ff) != S_SORT)
      else $error("count changed during dump or sort");
endmodule
`default_nettype wire

[src/vle_rsp_fifo.sv]
// Two-entry result queue that drives the rsp_ ports.
// Depends on vle_pkg.
`timescale 1ns / 1ps
`default_nettype none
module vle_rsp_fifo (
   input  wire              clock,
   input  wire              reset,
   input  vle_pkg::rsp_type wr_data,
   input  wire              wr_valid,
   output logic             wr_ready,
   output vle_pkg::rsp_type rd_data,
   output logic             empty,
   input  wire              pop
);
   import vle_pkg::*;
   rsp_type    mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;

   assign wr_ready = (cnt_ff != 2'd2);
   assign empty    = (cnt_ff == 2'd0);
   assign rd_data  = mem_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (wr_valid && wr_ready) mem_ff[wp_ff] <= wr_data;
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (wr_valid && wr_ready) wp_ff <= ~wp_ff;
         if (pop && !empty) rp_ff <= ~rp_ff;
         cnt_ff <= cnt_ff + {1'b0, wr_valid && wr_ready} - {1'b0, pop && !empty};
      end
   end
endmodule
`default_nettype wire

[src/value_list_engine_with_sort.sv]
// Value list engine with sort: top level. Depends on vle_pkg and the vle_ modules.
// The engine runs one command at a time; a dump gives one result a cycle while the
// result queue has room. A two-entry command queue in front and a two-entry result
// queue behind let both sides stall on their own.
// Reset (synchronous, active high) empties the list and both queues.
`timescale 1ns / 1ps
`default_nettype none
module value_list_engine_with_sort (
   input  wire              clock,
   input  wire              reset,
   input  vle_pkg::req_type req_data,
   input  wire              push,
   output logic             full,
   output vle_pkg::rsp_type rsp_data,
   output logic             empty,
   input  wire              pop
);
   import vle_pkg::*;
   req_type cmd;
   rsp_type eng_rsp;
   logic    cmd_empty, cmd_take, eng_valid, eng_ready;

   // front: queue each transaction
   vle_cmd_fifo u_cmd (
      .clock, .reset, .wr_data(req_data), .wr_en(push), .full,
      .rd_data(cmd), .empty(cmd_empty), .rd_en(cmd_take)
   );

   // back: carry out commands against the entry store
   vle_engine u_eng (
      .clock, .reset, .cmd, .cmd_valid(!cmd_empty), .cmd_take,
      .rsp_data(eng_rsp), .rsp_valid(eng_valid), .rsp_ready(eng_ready)
   );

   // hold results until popped
   vle_rsp_fifo u_rsp (
      .clock, .reset, .wr_data(eng_rsp), .wr_valid(eng_valid), .wr_ready(eng_ready),
      .rd_data(rsp_data), .empty, .pop
   );
endmodule
`default_nettype wire

[tb/vle_checker.sv]
// Checker for the value list engine: watches both queue ports, predicts each result
// from its own copy of the list and compares the whole result. Depends on vle_pkg.
`timescale 1ns / 1ps
module vle_checker (
   input  wire              clock,
   input  wire              reset,
   input  vle_pkg::req_type req_data,
   input  wire              push,
   input  wire              full,
   input  vle_pkg::rsp_type rsp_data,
   input  wire              empty,
   input  wire              pop,
   output int               fail_count,
   output int               pending_count,
   output int               rsp_seen
);
   import vle_pkg::*;

   logic signed [31:0] list_mirror [CAPACITY];
   int                 list_len;
   rsp_type            expected_rsps [$];

   function automatic rsp_type make_rsp(logic signed [31:0] v, logic [1:0] st, logic l);
      rsp_type r;
      r.item_value  = v;
      r.status      = st;
      r.entry_count = list_len[4:0];
      r.last        = l;
      return r;
   endfunction

   task automatic apply_command(req_type cmd);
      logic [1:0]         st;
      int                 i, j;
      logic signed [31:0] key;
      st = ST_OK;
      case (cmd.operation)
         OP_ADD_FRONT: begin
            if (list_len >= CAPACITY) st = ST_FULL;
            else begin
               for (i = list_len; i > 0; i--) list_mirror[i] = list_mirror[i-1];
               list_mirror[0] = cmd.value;
               list_len++;
            end
         end
         OP_APPEND: begin
            if (list_len >= CAPACITY) st = ST_FULL;
            else begin
               list_mirror[list_len] = cmd.value;
               list_len++;
            end
         end
         OP_DELETE: begin
            if (list_len == 0) st = ST_EMPTY;
            else begin
               for (i = 0; i < list_len; i++) if (list_mirror[i] == cmd.value) break;
               if (i == list_len) st = ST_MISSING;
               else begin
                  for (; i + 1 < list_len; i++) list_mirror[i] = list_mirror[i+1];
                  list_len--;
               end
            end
         end
         OP_SORT: begin
            for (i = 1; i < list_len; i++) begin
               key = list_mirror[i];
               j = i;
               while (j > 0 && key < list_mirror[j-1]) begin
                  list_mirror[j] = list_mirror[j-1];
                  j--;
               end
               list_mirror[j] = key;
            end
         end
         OP_DUMP: begin
            if (list_len == 0) expected_rsps.push_back(make_rsp('0, ST_EMPTY, 1'b1));
            else for (i = 0; i < list_len; i++)
               expected_rsps.push_back(make_rsp(list_mirror[i], ST_OK, i + 1 == list_len));
            return;
         end
         default: ;
      endcase
      expected_rsps.push_back(make_rsp('0, st, 1'b1));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         list_len = 0;
         expected_rsps.delete();
         fail_count = 0;
         rsp_seen = 0;
      end else begin
         if (pop && !empty) begin
            rsp_seen++;
            if (expected_rsps.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("ERROR: unexpected result %p", rsp_data);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_data !== want) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("ERROR: result mismatch, expected %p got %p", want, rsp_data);
               end
            end
         end
         if (push && !full) apply_command(req_data);
      end
      pending_count = expected_rsps.size();
   end
endmodule

[tb/tb_value_list_engine_with_sort.sv]
// Testbench top for value_list_engine_with_sort: drives commands, pops results with
// random stalls, and reports the verdict. Depends on vle_pkg and vle_checker.
`timescale 1ns / 1ps
module tb_value_list_engine_with_sort;
   import vle_pkg::*;

   localparam int IDLE_LIMIT = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   req_type req_data = '0;
   logic    push = 1'b0;
   logic    pop = 1'b0;
   logic    full, empty;
   rsp_type rsp_data;
   int      fail_count, pending_count, rsp_seen;
   int      idle_cycles = 0;
   bit      quiet_phase = 1'b0;
   bit      hold_off = 1'b0;
   logic signed [31:0] recent_vals [$];

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   value_list_engine_with_sort u_top (
      .clock, .reset, .req_data, .push, .full, .rsp_data, .empty, .pop
   );

   vle_checker u_checker (
      .clock, .reset, .req_data, .push, .full, .rsp_data, .empty, .pop,
      .fail_count, .pending_count, .rsp_seen
   );

   // Send one transaction: present it at the falling edge, hold until accepted.
   task automatic send_cmd(logic [2:0] op, logic signed [31:0] v);
      req_data.operation = op;
      req_data.value     = v;
      push = 1'b1;
      do @(posedge clock); while (full);
      @(negedge clock);
      if (!quiet_phase && $urandom_range(0, 3) == 0) begin
         push = 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
   endtask

   // Pick a value: often reuse recent ones so deletes hit, sometimes the extremes.
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 32'sh7fffffff;
         1: return 32'sh80000000;
         2, 3: if (recent_vals.size() > 0)
            return recent_vals[$urandom_range(0, recent_vals.size() - 1)];
         default: ;
      endcase
      return $urandom;
   endfunction

   task automatic random_cmd();
      int                 r;
      logic signed [31:0] v;
      r = $urandom_range(0, 99);
      v = pick_value();
      if (r < 30) begin
         send_cmd(OP_ADD_FRONT, v);
         recent_vals.push_back(v);
      end else if (r < 60) begin
         send_cmd(OP_APPEND, v);
         recent_vals.push_back(v);
      end else if (r < 78) send_cmd(OP_DELETE, v);
      else if (r < 86) send_cmd(OP_SORT, v);
      else if (r < 96) send_cmd(OP_DUMP, v);
      else send_cmd(3'($urandom_range(5, 7)), v);
      if (recent_vals.size() > 24) void'(recent_vals.pop_front());
   endtask

   // Receiver: pop with random stall bursts, none in the quiet phase; hold off on request.
   initial begin
      @(negedge clock);
      while (1) begin
         if (hold_off) begin
            pop = 1'b0;
         end else if (!quiet_phase && $urandom_range(0, 4) == 0) begin
            pop = 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
            pop = 1'b1;
         end else begin
            pop = 1'b1;
         end
         @(negedge clock);
      end
   end

   // Long receiver hold-off, counted here, while the sender keeps offering.
   initial begin
      wait (!reset);
      repeat (300) @(negedge clock);
      hold_off = 1'b1;
      repeat (400) @(negedge clock);
      hold_off = 1'b0;
   end

   // Watchdog: count cycles with no transaction on either port.
   always @(posedge clock) begin
      if ((push && !full) || (pop && !empty) || reset) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   initial begin
      int i;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty cases, extremes, fill to full, every operation.
      send_cmd(OP_DUMP, 0);
      send_cmd(OP_DELETE, 5);
      send_cmd(OP_SORT, 0);
      send_cmd(OP_APPEND, 32'sh7fffffff);
      send_cmd(OP_ADD_FRONT, 32'sh80000000);
      send_cmd(OP_APPEND, -1);
      send_cmd(OP_ADD_FRONT, 0);
      send_cmd(OP_DELETE, 12345);
      send_cmd(OP_DUMP, 0);
      send_cmd(OP_SORT, 0);
      send_cmd(OP_DUMP, 0);
      for (i = 0; i < 13; i++) send_cmd(i[0] ? OP_APPEND : OP_ADD_FRONT, $urandom);
      send_cmd(OP_APPEND, 1);
      send_cmd(OP_ADD_FRONT, 2);
      send_cmd(OP_SORT, 0);
      send_cmd(OP_DUMP, 0);
      send_cmd(3'd5, 0);
      send_cmd(3'd7, -1);
      for (i = 0; i < 16; i++) send_cmd(OP_DELETE, 32'sh80000000 + i);

      for (i = 0; i < 60; i++) begin
         if (i == 48) quiet_phase = 1'b1;
         random_cmd();
      end
      push = 1'b0;

      wait (pending_count == 0);
      repeat (300) @(posedge clock);
      $display("Covered %0d results: add front, append, delete hits and misses,", rsp_seen);
      $display("sort and dump on empty, partial and full lists, plus unused codes.");
      if (fail_count == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end
endmodule
